// ===== rtl/multi_queue_quantum_scheduler_macros.svh =====
// Assertion macros for the quantum scheduler
`ifndef MULTI_QUEUE_QUANTUM_SCHEDULER_MACROS_SVH
`define MULTI_QUEUE_QUANTUM_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define MQS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MQS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/mqqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mqqs_pkg;
   localparam int NUM_QUEUES_DEF  = 4;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam logic [11:0] QUANTUM_RESET = 12'd1000;

   localparam logic [1:0] OP_ENQ    = 2'd0;
   localparam logic [1:0] OP_DEQ    = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] ST_SENT    = 3'd0;
   localparam logic [2:0] ST_NONE    = 3'd1;
   localparam logic [2:0] ST_ENQ     = 3'd2;
   localparam logic [2:0] ST_DROPPED = 3'd3;
   localparam logic [2:0] ST_TICK    = 3'd4;

   localparam logic REG_QUANTUM = 1'b0;
   localparam logic REG_ORDER   = 1'b1;

   typedef struct packed {
      logic [10:0] size;
      logic [3:0]  prio;
      logic [11:0] ttl;
      logic [31:0] arrival;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_SCAN, S_SHIFT, S_RESP
   } state_type;

   // control for one queue's row of cells
   typedef struct packed {
      logic push;     // append at tail
      logic shift;    // one step of the removal pass
   } row_ctl_type;
endpackage
`default_nettype wire

// ===== rtl/mqqs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One slot: load from the input on push at tail, or take the right neighbour on shift.
module mqqs_cell (
   input  wire                 clock,
   input  wire                 load,
   input  wire                 take,
   input  mqqs_pkg::entry_type new_entry,
   input  mqqs_pkg::entry_type right_entry,
   output mqqs_pkg::entry_type entry
);
   mqqs_pkg::entry_type entry_ff, entry_in;
   always_comb begin
      entry_in = entry_ff;
      if (load) entry_in = new_entry;
      else if (take) entry_in = right_entry;
   end
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
   assign entry = entry_ff;
endmodule
`default_nettype wire

// ===== rtl/mqqs_row.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One queue: a row of cells, slot 0 is the head. Removal shifts left from a start slot.
module mqqs_row #(
   parameter int QUEUE_DEPTH = mqqs_pkg::QUEUE_DEPTH_DEF,
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  wire                  clock,
   input  mqqs_pkg::row_ctl_type ctl,
   input  wire [IW:0]           fill,
   input  wire [IW-1:0]         from_slot,
   input  mqqs_pkg::entry_type  new_entry,
   input  wire [IW-1:0]         rd_slot,
   output mqqs_pkg::entry_type  rd_entry
);
   mqqs_pkg::entry_type slots [QUEUE_DEPTH];
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      mqqs_pkg::entry_type right;
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right = slots[i];
      end else begin : g_mid
         assign right = slots[i+1];
      end
      mqqs_cell u_cell (
         .clock(clock),
         .load(ctl.push && (fill == (IW+1)'(i))),
         .take(ctl.shift && (IW'(i) >= from_slot)),
         .new_entry(new_entry),
         .right_entry(right),
         .entry(slots[i])
      );
   end
   assign rd_entry = slots[rd_slot];
endmodule
`default_nettype wire

// ===== rtl/multi_queue_quantum_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Handshake          | Beat contents
// req     | start & !busy      | opcode, queue_index, packet_size/priority/ttl
// rsp     | rsp_valid (1 cyc)  | status, served_queue, out_size/priority, timed_out
// csr     | csr_valid & ready  | csr_index, csr_data
// Enqueue and tick go from FIND to RESP. Dequeue in FIFO order goes FIND, SCAN, SHIFT, RESP;
// in priority order SCAN repeats, the scan walking one slot a cycle through the chosen
// row. Finding the queue is one NUM_QUEUES-way pick in FIND; with none found, RESP follows.
// Reset is synchronous and clears fills, pointer, budget and clock; slots hold junk.
// The receiver cannot stall: each result is shown for one cycle only.
module multi_queue_quantum_scheduler #(
   parameter int NUM_QUEUES  = mqqs_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = mqqs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_opcode,
   input  wire  [1:0]  req_queue_index,
   input  wire  [10:0] req_packet_size,
   input  wire  [3:0]  req_packet_priority,
   input  wire  [11:0] req_packet_ttl,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_served_queue,
   output logic [10:0] rsp_out_size,
   output logic [3:0]  rsp_out_priority,
   output logic        rsp_timed_out,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [11:0] csr_data
);
`include "multi_queue_quantum_scheduler_macros.svh"
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   mqqs_pkg::state_type state_ff, state_in;
   logic [11:0] quantum_ff;
   logic        order_ff;
   logic [IW:0] fill_ff [NUM_QUEUES];
   logic [QW-1:0] cur_ff, q_ff, q_in;
   logic [12:0] budget_ff;
   logic [31:0] now_ff;
   logic [IW-1:0] scan_ff, best_ff;
   logic [3:0]  best_prio_ff;
   // request latch
   logic [1:0]  op_ff;
   logic [1:0]  qi_ff;
   mqqs_pkg::entry_type req_ff;
   // response
   logic        rv_ff;
   logic [2:0]  st_ff;
   logic [1:0]  sq_ff;
   logic [10:0] sz_ff;
   logic [3:0]  pr_ff;
   logic        to_ff;

   mqqs_pkg::entry_type rd_entry [NUM_QUEUES];
   mqqs_pkg::entry_type sel_entry;
   logic found;
   logic enq_ok;
   logic [12:0] budget_sum;

   assign busy      = (state_ff != mqqs_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   wire accept = start && !busy;

   // queue index in range and not full
   always_comb begin
      enq_ok = 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++)
         if (32'(qi_ff) == i && fill_ff[i] < (IW+1)'(QUEUE_DEPTH)) enq_ok = 1'b1;
   end

   // pick first non-empty queue at or after the pointer; wrap by compare and subtract
   always_comb begin
      int idx;
      found = 1'b0;
      q_in  = cur_ff;
      for (int k = NUM_QUEUES - 1; k >= 0; k--) begin
         idx = int'(cur_ff) + k;
         if (idx >= NUM_QUEUES) idx = idx - NUM_QUEUES;
         if (fill_ff[idx] != '0) begin
            found = 1'b1;
            q_in  = QW'(idx);
         end
      end
   end

   // rows of cells
   for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_row
      mqqs_pkg::row_ctl_type ctl;
      assign ctl.push  = (state_ff == mqqs_pkg::S_FIND) && (op_ff == mqqs_pkg::OP_ENQ)
                         && enq_ok && (32'(qi_ff) == g);
      assign ctl.shift = (state_ff == mqqs_pkg::S_SHIFT) && (32'(q_ff) == g);
      mqqs_row #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_row (
         .clock(clock), .ctl(ctl), .fill(fill_ff[g]), .from_slot(best_ff),
         .new_entry(req_ff),
         .rd_slot((state_ff == mqqs_pkg::S_SCAN) ? scan_ff : best_ff),
         .rd_entry(rd_entry[g])
      );
   end
   assign sel_entry  = rd_entry[q_ff];
   assign budget_sum = budget_ff + 13'(sel_entry.size);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mqqs_pkg::S_IDLE:  if (accept) state_in = mqqs_pkg::S_FIND;
         mqqs_pkg::S_FIND: begin
            if (op_ff == mqqs_pkg::OP_DEQ && found) state_in = mqqs_pkg::S_SCAN;
            else state_in = mqqs_pkg::S_RESP;
         end
         mqqs_pkg::S_SCAN: begin
            if (!order_ff || (IW+1)'(scan_ff) + 1'b1 >= fill_ff[q_ff])
               state_in = mqqs_pkg::S_SHIFT;
         end
         mqqs_pkg::S_SHIFT: state_in = mqqs_pkg::S_RESP;
         mqqs_pkg::S_RESP:  state_in = mqqs_pkg::S_IDLE;
         default:           state_in = mqqs_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mqqs_pkg::S_IDLE;
         quantum_ff <= mqqs_pkg::QUANTUM_RESET;
         order_ff   <= 1'b0;
         cur_ff     <= '0;
         budget_ff  <= '0;
         now_ff     <= '0;
         rv_ff      <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) fill_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               mqqs_pkg::REG_QUANTUM: quantum_ff <= csr_data;
               mqqs_pkg::REG_ORDER:   order_ff   <= csr_data[0];
               default: ;
            endcase
         end
         unique case (state_ff)
            mqqs_pkg::S_FIND: begin
               q_ff    <= q_in;
               scan_ff <= '0;
               best_ff <= '0;
               best_prio_ff <= '0;
               st_ff <= mqqs_pkg::ST_NONE;
               sq_ff <= '0; sz_ff <= '0; pr_ff <= '0; to_ff <= 1'b0;
               priority case (op_ff)
                  mqqs_pkg::OP_ENQ: begin
                     if (enq_ok) begin
                        st_ff <= mqqs_pkg::ST_ENQ;
                        fill_ff[qi_ff[QW-1:0]] <= fill_ff[qi_ff[QW-1:0]] + 1'b1;
                     end else st_ff <= mqqs_pkg::ST_DROPPED;
                  end
                  mqqs_pkg::OP_TICK: begin
                     now_ff <= now_ff + 32'd1;
                     st_ff  <= mqqs_pkg::ST_TICK;
                  end
                  default: ;
               endcase
            end
            mqqs_pkg::S_SCAN: begin
               // hold the strictly higher priority; oldest wins ties
               if (scan_ff == '0 || sel_entry.prio > best_prio_ff) begin
                  best_ff      <= scan_ff;
                  best_prio_ff <= sel_entry.prio;
               end
               scan_ff <= scan_ff + 1'b1;
            end
            mqqs_pkg::S_SHIFT: begin
               // rd_slot is best_ff here, so sel_entry is the packet sent
               fill_ff[q_ff] <= fill_ff[q_ff] - 1'b1;
               st_ff <= mqqs_pkg::ST_SENT;
               sq_ff <= 2'(q_ff);
               sz_ff <= sel_entry.size;
               pr_ff <= sel_entry.prio;
               to_ff <= (now_ff - sel_entry.arrival) > 32'(sel_entry.ttl);
               if (budget_sum >= 13'(quantum_ff)) begin
                  budget_ff <= '0;
                  cur_ff <= (q_ff == QW'(NUM_QUEUES - 1)) ? '0 : q_ff + 1'b1;
               end else begin
                  budget_ff <= budget_sum;
                  cur_ff <= q_ff;
               end
            end
            mqqs_pkg::S_RESP: rv_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_opcode;
         qi_ff <= req_queue_index;
         req_ff.size    <= req_packet_size;
         req_ff.prio    <= req_packet_priority;
         req_ff.ttl     <= req_packet_ttl;
         req_ff.arrival <= now_ff;
      end
   end

   // outputs
   always_comb begin
      rsp_valid        = rv_ff;
      rsp_status       = st_ff;
      rsp_served_queue = sq_ff;
      rsp_out_size     = sz_ff;
      rsp_out_priority = pr_ff;
      rsp_timed_out    = to_ff;
   end

   `MQS_ASSERT_NEXT(a_rsp_one, clock, reset, rsp_valid, !rsp_valid, "result held twice")
   `MQS_ASSERT_IMPL(a_busy_rsp, clock, reset, rsp_valid, !busy, "result while busy")
   `MQS_ASSERT_NEXT(a_accept, clock, reset, accept, busy, "accept did not start work")
   `MQS_ASSERT_IMPL(a_sent_fields, clock, reset, rsp_valid && rsp_status != mqqs_pkg::ST_SENT, rsp_out_size == 11'd0 && !rsp_timed_out, "fields not cleared")
endmodule
`default_nettype wire
